[rtl/assert_macros.svh]
// Assertion macros used by the top level of the pulse window energy detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside reset.
`define PWED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a rising edge of clk outside reset.
`define PWED_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/pwed_pkg.sv]
// Package with the constants, item types and codes of the pulse window energy detector.
`default_nettype none

package pwed_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DC_SHIFT    = 9;
  localparam int DC_FRAC     = 16;
  localparam int SQ_SHIFT    = 10;

  // The DC tracker never leaves the range of a sample shifted up by DC_FRAC.
  localparam int DC_W   = SAMPLE_BITS + DC_FRAC;
  // AC level plus half scale needs one bit of headroom and a sign bit.
  localparam int LVL_W  = SAMPLE_BITS + 2;
  localparam int SQ_W   = 2 * SAMPLE_BITS - SQ_SHIFT;
  localparam int ENER_W = 32;
  localparam int TALLY_W = 16;
  localparam int CNT_W  = 8;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic CH_IR  = 1'b0;
  localparam logic CH_RED = 1'b1;

  localparam logic REG_DEBOUNCE_LIMIT = 1'b0;
  localparam logic REG_HALFCYC_LIMIT  = 1'b1;

  localparam logic [CNT_W-1:0] DEBOUNCE_LIMIT_RST = 8'd4;
  localparam logic [CNT_W-1:0] HALFCYC_LIMIT_RST  = 8'd10;

  typedef struct packed {
    logic                   channel;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [TALLY_W-1:0] window_samples;
    logic [ENER_W-1:0]  ir_energy;
    logic [ENER_W-1:0]  red_energy;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/pwed_ac_unit.sv]
// DC tracker step, AC level and saturating energy accumulation for one sample.
`default_nettype none

module pwed_ac_unit (
  input  wire logic [pwed_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic [pwed_pkg::DC_W-1:0]        dc,
  input  wire logic [pwed_pkg::ENER_W-1:0]      energy,
  output logic      [pwed_pkg::DC_W-1:0]        dc_nxt,
  output logic      [pwed_pkg::ENER_W-1:0]      energy_nxt,
  output logic signed [pwed_pkg::LVL_W-1:0]     ac
);

  localparam int SB  = pwed_pkg::SAMPLE_BITS;
  localparam int DW  = pwed_pkg::DC_W;
  localparam int EW  = pwed_pkg::ENER_W;
  localparam int LW  = pwed_pkg::LVL_W;
  localparam int SQW = pwed_pkg::SQ_W;

  logic [DW-1:0]        target;
  logic signed [DW:0]   diff;
  logic signed [DW:0]   step;
  logic signed [DW:0]   dc_sum;
  logic [SB-1:0]        dc_int;
  logic [LW-1:0]        ac_abs;
  logic [SB-1:0]        mag;
  logic [2*SB-1:0]      square;
  logic [EW:0]          energy_ext;

  always_comb begin
    target = {sample, {pwed_pkg::DC_FRAC{1'b0}}};
    diff   = $signed({1'b0, target}) - $signed({1'b0, dc});
    // Arithmetic shift floors toward minus infinity, as the tracker requires.
    step   = diff >>> pwed_pkg::DC_SHIFT;
    dc_sum = $signed({1'b0, dc}) + step;
    dc_nxt = dc_sum[DW-1:0];
    dc_int = dc_nxt[DW-1:pwed_pkg::DC_FRAC];
    ac     = $signed({2'b00, sample}) - $signed({2'b00, dc_int});
    ac_abs = ac[LW-1] ? LW'(-ac) : LW'(ac);
    mag    = ac_abs[SB-1:0];
    square = mag * mag;
    energy_ext = {1'b0, energy} + {{(EW + 1 - SQW){1'b0}}, square[2*SB-1:pwed_pkg::SQ_SHIFT]};
    energy_nxt = energy_ext[EW] ? {EW{1'b1}} : energy_ext[EW-1:0];
  end

endmodule

`default_nettype wire

[rtl/pulse_window_energy_detector.sv]
// Top level of the pulse window energy detector: input and result registers, tracker, config.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_data  (pwed_pkg::in_item_t)
//   out_      output     out_valid/out_stall  out_data (pwed_pkg::out_item_t)
//   config    input      psel/penable/pready  paddr, pwdata, prdata
//
// A result reaches out_data through the input register, where its item sits, and the result
// register: the DC, square and tracker update run in a single pass between the two.
// One item is accepted every cycle unless a result is held under out_stall.
// Reset is synchronous; it clears all tracking state and loads the register defaults.
// While a result waits under out_stall, one more item is taken into the input register.
`default_nettype none

module pulse_window_energy_detector (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire pwed_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output pwed_pkg::out_item_t                out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pwed_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pwed_pkg::DATA_W-1:0]   pwdata,
  output logic      [pwed_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  `include "assert_macros.svh"

  localparam int DW = pwed_pkg::DC_W;
  localparam int EW = pwed_pkg::ENER_W;
  localparam int LW = pwed_pkg::LVL_W;
  localparam int TW = pwed_pkg::TALLY_W;
  localparam int CW = pwed_pkg::CNT_W;
  localparam int SB = pwed_pkg::SAMPLE_BITS;

  logic                in_vld_r;
  pwed_pkg::in_item_t  in_item_r;
  logic                out_vld_r;
  pwed_pkg::out_item_t out_item_r, out_item_nxt;

  logic [CW-1:0] debounce_limit_r, halfcyc_limit_r;

  logic [DW-1:0]        ir_dc_r, ir_dc_nxt, red_dc_r, red_dc_nxt;
  logic [EW-1:0]        ir_sum_r, ir_sum_nxt, red_sum_r, red_sum_nxt;
  logic [TW-1:0]        sample_tally_r, sample_tally_nxt;
  logic [CW-1:0]        halfcyc_r, halfcyc_nxt;
  logic [CW-1:0]        debounce_r, debounce_nxt;
  logic                 rising_r, rising_nxt;
  logic signed [LW-1:0] extreme_r, extreme_nxt;

  logic                 proc;
  logic                 is_ir;
  logic                 emit;
  logic                 cfg_wr;
  logic [DW-1:0]        dc_sel, dc_new;
  logic [EW-1:0]        sum_sel, sum_new;
  logic signed [LW-1:0] ac;
  logic signed [LW-1:0] level;
  logic                 extends_edge;
  logic [CW-1:0]        deb_inc;
  logic [CW-1:0]        halfcyc_inc;

  // The item in the input register moves on unless a result is held under stall.
  assign proc     = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;
  assign is_ir    = (in_item_r.channel == pwed_pkg::CH_IR);

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      pwed_pkg::REG_DEBOUNCE_LIMIT: prdata = {{(pwed_pkg::DATA_W - CW){1'b0}}, debounce_limit_r};
      pwed_pkg::REG_HALFCYC_LIMIT:  prdata = {{(pwed_pkg::DATA_W - CW){1'b0}}, halfcyc_limit_r};
      default:                      prdata = '0;
    endcase
  end

  assign dc_sel  = is_ir ? ir_dc_r : red_dc_r;
  assign sum_sel = is_ir ? ir_sum_r : red_sum_r;

  pwed_ac_unit u_ac (
    .sample     (in_item_r.sample),
    .dc         (dc_sel),
    .energy     (sum_sel),
    .dc_nxt     (dc_new),
    .energy_nxt (sum_new),
    .ac         (ac)
  );

  always_comb begin
    ir_dc_nxt        = ir_dc_r;
    red_dc_nxt       = red_dc_r;
    ir_sum_nxt       = ir_sum_r;
    red_sum_nxt      = red_sum_r;
    sample_tally_nxt = sample_tally_r;
    halfcyc_nxt      = halfcyc_r;
    debounce_nxt     = debounce_r;
    rising_nxt       = rising_r;
    extreme_nxt      = extreme_r;
    emit             = 1'b0;

    level        = ac + $signed({2'b00, 1'b1, {(SB - 1){1'b0}}});
    extends_edge = rising_r ? (extreme_r <= level) : (extreme_r >= level);
    deb_inc      = (debounce_r == {CW{1'b1}}) ? debounce_r : debounce_r + 1'b1;
    halfcyc_inc  = halfcyc_r + 1'b1;

    out_item_nxt.window_samples = '0;
    out_item_nxt.ir_energy      = '0;
    out_item_nxt.red_energy     = '0;

    if (proc) begin
      if (!is_ir) begin
        red_dc_nxt  = dc_new;
        red_sum_nxt = sum_new;
      end else begin
        ir_dc_nxt  = dc_new;
        ir_sum_nxt = sum_new;
        if (sample_tally_r != {TW{1'b1}}) begin
          sample_tally_nxt = sample_tally_r + 1'b1;
        end
        // A level that continues the current edge restarts the debounce count.
        if (extends_edge) begin
          debounce_nxt = '0;
          extreme_nxt  = level;
        end else if (deb_inc >= debounce_limit_r) begin
          rising_nxt   = !rising_r;
          debounce_nxt = '0;
          halfcyc_nxt  = halfcyc_inc;
        end else begin
          debounce_nxt = deb_inc;
        end

        emit = (halfcyc_nxt >= halfcyc_limit_r);
        out_item_nxt.window_samples = sample_tally_nxt;
        out_item_nxt.ir_energy      = ir_sum_nxt;
        out_item_nxt.red_energy     = red_sum_r;
        if (emit) begin
          ir_sum_nxt       = '0;
          red_sum_nxt      = '0;
          sample_tally_nxt = '0;
          halfcyc_nxt      = '0;
          debounce_nxt     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r         <= 1'b0;
      out_vld_r        <= 1'b0;
      debounce_limit_r <= pwed_pkg::DEBOUNCE_LIMIT_RST;
      halfcyc_limit_r  <= pwed_pkg::HALFCYC_LIMIT_RST;
      ir_dc_r          <= '0;
      red_dc_r         <= '0;
      ir_sum_r         <= '0;
      red_sum_r        <= '0;
      sample_tally_r   <= '0;
      halfcyc_r        <= '0;
      debounce_r       <= '0;
      rising_r         <= 1'b0;
      extreme_r        <= '0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (proc && emit) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (paddr[2])
          pwed_pkg::REG_DEBOUNCE_LIMIT: debounce_limit_r <= pwdata[CW-1:0];
          pwed_pkg::REG_HALFCYC_LIMIT:  halfcyc_limit_r  <= pwdata[CW-1:0];
          default: ;
        endcase
      end
      ir_dc_r        <= ir_dc_nxt;
      red_dc_r       <= red_dc_nxt;
      ir_sum_r       <= ir_sum_nxt;
      red_sum_r      <= red_sum_nxt;
      sample_tally_r <= sample_tally_nxt;
      halfcyc_r      <= halfcyc_nxt;
      debounce_r     <= debounce_nxt;
      rising_r       <= rising_nxt;
      extreme_r      <= extreme_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_data;
    end
    if (proc && emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  `PWED_ASSERT(a_result_from_ir, (proc && emit) |-> is_ir, "result raised by a red item")
  `PWED_NEVER(a_no_overwrite, proc && out_vld_r && out_stall, "item processed over a held result")
  `PWED_ASSERT(a_window_clear, (proc && emit) |=> (halfcyc_r == '0 && ir_sum_r == '0), "window kept")

endmodule

`default_nettype wire
